// ===== design/pcfw_pkg.sv =====
// Shared types and codes of the page cache slot manager.
package pcfw_pkg;

    // Field widths fixed by the beat formats
    localparam int FUNC_W  = 2;
    localparam int PAGE_W  = 16;
    localparam int KIND_W  = 3;
    localparam int SLOTF_W = 4;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    // Result kind codes
    localparam logic [KIND_W-1:0] KIND_READ_MISS    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ_HIT     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_HIT    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE_ALLOC  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WRITE_REJECT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK    = 3'd5;
    localparam logic [KIND_W-1:0] KIND_FLUSH_DONE   = 3'd6;

    // Request beat
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page;
    } req_t;

    // Result beat
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SLOTF_W-1:0] slot;
        logic [PAGE_W-1:0]  victim_page;
        logic               last;
    } rsp_t;

    // Memory port command
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_cmd_t;

endpackage

// ===== design/page_cache_fifo_writeback_core.sv =====
// Top level of the page cache slot manager with FIFO replacement and write-back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+--------------------------------------
//  request  | req_valid / req_stall   | req  (func, page)
//  result   | rsp_valid / rsp_stall   | rsp  (kind, slot, victim_page, last)
//  config   | cfg_write               | cfg_data (writeback_enable)
//
// Read, write hit, write allocate and reject: map read, then decide.
// Write with eviction: map read, owner read, unmap victim, bind new page.
// Flush: for N > 0 allocated slots, N write-back beats, then done; empty: done alone.
// After reset the page map is cleared one entry per cycle, all 2**PAGE_BITS entries,
// with req_stall high; configuration writes are taken during that time.
// A stalled result holds the sequencer in its current step; one result register.
module page_cache_fifo_writeback_core #(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  pcfw_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output pcfw_pkg::rsp_t rsp,
    input  logic           cfg_write,
    input  logic           cfg_data
);
    import pcfw_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);

    mem_cmd_t             map_cmd;
    logic [PAGE_BITS-1:0] map_addr;
    logic [SLOT_W:0]      map_wdata;
    logic [SLOT_W:0]      map_rdata;
    logic                 map_ready;
    mem_cmd_t             own_cmd;
    logic [SLOT_W-1:0]    own_addr;
    logic [PAGE_BITS-1:0] own_wdata;
    logic [PAGE_BITS-1:0] own_rdata;

    // Page map: valid bit and slot per page
    pcfw_page_map #(
        .ADDR_W (PAGE_BITS),
        .DATA_W (SLOT_W + 1)
    ) u_page_map (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (map_cmd),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata),
        .ready (map_ready)
    );

    // Owner page per slot
    pcfw_slot_owner #(
        .SLOTS  (SLOTS),
        .DATA_W (PAGE_BITS)
    ) u_slot_owner (
        .clk   (clk),
        .cmd   (own_cmd),
        .addr  (own_addr),
        .wdata (own_wdata),
        .rdata (own_rdata)
    );

    // Sequencer and result register
    pcfw_ctrl #(
        .SLOTS     (SLOTS),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .map_ready (map_ready),
        .map_cmd   (map_cmd),
        .map_addr  (map_addr),
        .map_wdata (map_wdata),
        .map_rdata (map_rdata),
        .own_cmd   (own_cmd),
        .own_addr  (own_addr),
        .own_wdata (own_wdata),
        .own_rdata (own_rdata)
    );

endmodule

// ===== design/pcfw_page_map.sv =====
// Page-to-slot map memory with a clearing pass after reset.
module pcfw_page_map #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pcfw_pkg::mem_cmd_t cmd,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata,
    output logic              ready
);
    import pcfw_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    // Clear sweep: one entry per cycle from address zero up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clr_active_reg;

endmodule

// ===== design/pcfw_slot_owner.sv =====
// Slot owner memory: the page each allocated slot holds.
module pcfw_slot_owner #(
    parameter int SLOTS  = 16,
    parameter int DATA_W = 16
) (
    input  logic                     clk,
    input  pcfw_pkg::mem_cmd_t        cmd,
    input  logic [$clog2(SLOTS)-1:0] addr,
    input  logic [DATA_W-1:0]        wdata,
    output logic [DATA_W-1:0]        rdata
);
    import pcfw_pkg::*;

    logic [DATA_W-1:0] mem [SLOTS];
    logic [DATA_W-1:0] rdata_reg;

    // Single port, registered read; data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (cmd.wr)
        begin
            mem[addr] <= wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pcfw_ctrl.sv =====
// Request sequencer: map lookup, slot allocation, eviction, flush and result register.
module pcfw_ctrl #(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     req_valid,
    output logic                     req_stall,
    input  pcfw_pkg::req_t           req,
    // result channel
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output pcfw_pkg::rsp_t           rsp,
    // configuration
    input  logic                     cfg_write,
    input  logic                     cfg_data,
    // page map port
    input  logic                     map_ready,
    output pcfw_pkg::mem_cmd_t        map_cmd,
    output logic [PAGE_BITS-1:0]     map_addr,
    output logic [$clog2(SLOTS):0]   map_wdata,
    input  logic [$clog2(SLOTS):0]   map_rdata,
    // slot owner port
    output pcfw_pkg::mem_cmd_t        own_cmd,
    output logic [$clog2(SLOTS)-1:0] own_addr,
    output logic [PAGE_BITS-1:0]     own_wdata,
    input  logic [PAGE_BITS-1:0]     own_rdata
);
    import pcfw_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SUM_W  = SLOT_W + 2;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_EVICT  = 6'b000100,
        ST_ALLOC  = 6'b001000,
        ST_FLUSH  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    head_reg, head_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic                 wb_en_reg;
    logic                 rsp_valid_reg;
    rsp_t                 rsp_reg;

    logic                 accept;
    logic                 can_emit;
    logic                 emit;
    rsp_t                 rsp_next;
    logic [SUM_W-1:0]     free_sum;
    logic [SLOT_W-1:0]    free_slot;
    logic [SLOT_W-1:0]    head_inc;
    logic                 entry_valid;
    logic [SLOT_W-1:0]    entry_slot;

    // Allocated slots sit at head..head+cnt-1 of a fixed slot ring, free ones follow,
    // so the oldest slot is head and the next free slot is head+cnt
    assign free_sum  = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign free_slot = (free_sum >= SUM_W'(SLOTS)) ? SLOT_W'(free_sum - SUM_W'(SLOTS))
                                                   : SLOT_W'(free_sum);
    assign head_inc  = (head_reg == SLOT_W'(SLOTS - 1)) ? '0 : head_reg + 1'b1;

    assign entry_valid = map_rdata[SLOT_W];
    assign entry_slot  = map_rdata[SLOT_W-1:0];

    assign req_stall = (state_reg != ST_IDLE) || !map_ready;
    assign accept    = req_valid && !req_stall;
    assign can_emit  = !rsp_valid_reg || !rsp_stall;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        func_next  = func_reg;
        page_next  = page_reg;
        slot_next  = slot_reg;
        emit       = 1'b0;
        rsp_next   = '0;
        map_cmd    = '0;
        map_addr   = page_reg;
        map_wdata  = '0;
        own_cmd    = '0;
        own_addr   = head_reg;
        own_wdata  = page_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next  = req.func;
                    page_next  = PAGE_BITS'(req.page);
                    map_cmd.rd = 1'b1;
                    map_addr   = PAGE_BITS'(req.page);
                    state_next = ST_LOOKUP;
                end
            end

            ST_LOOKUP:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                    case (func_reg)
                        FUNC_READ:
                        begin
                            emit          = 1'b1;
                            rsp_next.last = 1'b1;
                            if (entry_valid)
                            begin
                                rsp_next.kind = KIND_READ_HIT;
                                rsp_next.slot = SLOTF_W'(entry_slot);
                            end
                            else
                            begin
                                rsp_next.kind = KIND_READ_MISS;
                            end
                        end

                        FUNC_WRITE:
                        begin
                            if (entry_valid)
                            begin
                                emit          = 1'b1;
                                rsp_next.kind = KIND_WRITE_HIT;
                                rsp_next.slot = SLOTF_W'(entry_slot);
                                rsp_next.last = 1'b1;
                            end
                            else if (cnt_reg < CNT_W'(SLOTS))
                            begin
                                // take the next free slot and bind it
                                map_cmd.wr    = 1'b1;
                                map_wdata     = {1'b1, free_slot};
                                own_cmd.wr    = 1'b1;
                                own_addr      = free_slot;
                                cnt_next      = cnt_reg + 1'b1;
                                emit          = 1'b1;
                                rsp_next.kind = KIND_WRITE_ALLOC;
                                rsp_next.slot = SLOTF_W'(free_slot);
                                rsp_next.last = 1'b1;
                            end
                            else if (!wb_en_reg)
                            begin
                                emit          = 1'b1;
                                rsp_next.kind = KIND_WRITE_REJECT;
                                rsp_next.last = 1'b1;
                            end
                            else
                            begin
                                // fetch the owner of the oldest slot
                                own_cmd.rd = 1'b1;
                                slot_next  = head_reg;
                                state_next = ST_EVICT;
                            end
                        end

                        FUNC_FLUSH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                emit          = 1'b1;
                                rsp_next.kind = KIND_FLUSH_DONE;
                                rsp_next.last = 1'b1;
                            end
                            else
                            begin
                                own_cmd.rd = 1'b1;
                                state_next = ST_FLUSH;
                            end
                        end

                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_EVICT:
            begin
                if (can_emit)
                begin
                    // unmap the victim page and report its write-back
                    map_cmd.wr           = 1'b1;
                    map_addr             = own_rdata;
                    emit                 = 1'b1;
                    rsp_next.kind        = KIND_WRITEBACK;
                    rsp_next.slot        = SLOTF_W'(slot_reg);
                    rsp_next.victim_page = PAGE_W'(own_rdata);
                    head_next            = head_inc;
                    state_next           = ST_ALLOC;
                end
            end

            ST_ALLOC:
            begin
                if (can_emit)
                begin
                    map_cmd.wr    = 1'b1;
                    map_wdata     = {1'b1, slot_reg};
                    own_cmd.wr    = 1'b1;
                    own_addr      = slot_reg;
                    emit          = 1'b1;
                    rsp_next.kind = KIND_WRITE_ALLOC;
                    rsp_next.slot = SLOTF_W'(slot_reg);
                    rsp_next.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    // one write-back per cycle while the result is not stalled, oldest first
                    map_cmd.wr           = 1'b1;
                    map_addr             = own_rdata;
                    emit                 = 1'b1;
                    rsp_next.kind        = KIND_WRITEBACK;
                    rsp_next.slot        = SLOTF_W'(head_reg);
                    rsp_next.victim_page = PAGE_W'(own_rdata);
                    head_next            = head_inc;
                    cnt_next             = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        own_cmd.rd = 1'b1;
                        own_addr   = head_inc;
                    end
                end
            end

            ST_DONE:
            begin
                if (can_emit)
                begin
                    emit          = 1'b1;
                    rsp_next.kind = KIND_FLUSH_DONE;
                    rsp_next.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            wb_en_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            if (cfg_write)
            begin
                wb_en_reg <= cfg_data;
            end
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        page_reg <= page_next;
        slot_reg <= slot_next;
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Allocated count never exceeds the slot count
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(SLOTS))
        else $error("allocated count above slot count");

    // A result is only loaded when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> can_emit)
        else $error("result register overwritten");

    // Write-backs come only from eviction or flush
    a_wb_source: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && rsp_next.kind == KIND_WRITEBACK) |->
        (state_reg == ST_EVICT || state_reg == ST_FLUSH))
        else $error("write-back from wrong state");

    // An eviction is always followed by the allocation of the same slot
    a_evict_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT && can_emit) |=> (state_reg == ST_ALLOC && $stable(slot_reg)))
        else $error("eviction not followed by allocation");

    // Eviction only when every slot is allocated
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVICT) |-> (cnt_reg == CNT_W'(SLOTS)))
        else $error("eviction with a free slot");

endmodule

// ===== tb/sv/tb_page_cache_fifo_writeback_core.sv =====
// Self-checking testbench of the page cache slot manager against a cache predictor.
module tb_page_cache_fifo_writeback_core;

    import pcfw_pkg::*;

    localparam int N_SLOTS       = 16;
    localparam int MAP_DEPTH     = 1 << PAGE_W;
    localparam int HOT_COUNT     = 24;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 32;
    localparam int RUN_LIMIT     = 5_000_000;
    localparam int REPORT_CAP    = 50;

    // Function code with no meaning: no result, no state change
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // Steps of the stimulus plan
    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_DRAIN
    } step_kind_t;

    typedef struct {
        step_kind_t kind;
        req_t       beat;
        logic       wb_en;
    } step_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_write = 1'b0;
    logic cfg_data  = 1'b0;

    page_cache_fifo_writeback_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Predicted cache state
    logic               map_valid [0:MAP_DEPTH-1];
    logic [SLOTF_W-1:0] map_slot  [0:MAP_DEPTH-1];
    logic [PAGE_W-1:0]  slot_page [0:N_SLOTS-1];
    logic [SLOTF_W-1:0] free_ring [0:N_SLOTS-1];
    logic [SLOTF_W-1:0] free_head;
    logic [4:0]         free_cnt;
    logic [SLOTF_W-1:0] age_ring  [0:N_SLOTS-1];
    logic [SLOTF_W-1:0] age_head;
    logic [4:0]         age_cnt;
    logic               wb_enable;

    step_t             pending_steps [$];
    rsp_t              due_results   [$];
    logic [PAGE_W-1:0] hot_pages [0:HOT_COUNT-1];

    int exp_total  = 0;
    int got_total  = 0;
    int err_count  = 0;
    int req_sent   = 0;
    int wb_seen    = 0;
    int rej_seen   = 0;
    int send_gap   = 0;
    int send_quiet = 0;
    int settle     = 0;
    int rcv_hold   = 0;
    int rcv_quiet  = 0;

    // Per-beat wait, with occasional stretches of no idling
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 5) == 0)
        begin
            quiet = $urandom_range(8, 20);
            return 0;
        end
        return $urandom_range(0, 8);
    endfunction

    function automatic void push_result(logic [KIND_W-1:0] k, logic [SLOTF_W-1:0] s,
                                        logic [PAGE_W-1:0] v, logic l);
        rsp_t b;
        b.kind        = k;
        b.slot        = s;
        b.victim_page = v;
        b.last        = l;
        due_results.push_back(b);
        exp_total++;
    endfunction

    // Map a page to a slot and append the slot to the age order
    function automatic void claim_slot(logic [SLOTF_W-1:0] s, logic [PAGE_W-1:0] pg);
        logic [SLOTF_W-1:0] pos;
        pos           = age_head + age_cnt[3:0];
        age_ring[pos] = s;
        age_cnt++;
        map_valid[pg] = 1'b1;
        map_slot[pg]  = s;
        slot_page[s]  = pg;
    endfunction

    // Lookup, allocate, evict or flush for one accepted request
    function automatic void resolve_request(req_t r);
        logic [PAGE_W-1:0]  pg;
        logic [PAGE_W-1:0]  victim;
        logic [SLOTF_W-1:0] s;
        logic [SLOTF_W-1:0] pos;
        pg = r.page;
        case (r.func)
            FUNC_READ:
            begin
                if (map_valid[pg])
                    push_result(KIND_READ_HIT, map_slot[pg], '0, 1'b1);
                else
                    push_result(KIND_READ_MISS, '0, '0, 1'b1);
            end
            FUNC_WRITE:
            begin
                if (map_valid[pg])
                    push_result(KIND_WRITE_HIT, map_slot[pg], '0, 1'b1);
                else if (free_cnt != 0)
                begin
                    s = free_ring[free_head];
                    free_head++;
                    free_cnt--;
                    claim_slot(s, pg);
                    push_result(KIND_WRITE_ALLOC, s, '0, 1'b1);
                end
                else if (!wb_enable || age_cnt == 0)
                    push_result(KIND_WRITE_REJECT, '0, '0, 1'b1);
                else
                begin
                    // evict the oldest slot, then hand it to the new page
                    s = age_ring[age_head];
                    age_head++;
                    age_cnt--;
                    victim            = slot_page[s];
                    map_valid[victim] = 1'b0;
                    push_result(KIND_WRITEBACK, s, victim, 1'b0);
                    claim_slot(s, pg);
                    push_result(KIND_WRITE_ALLOC, s, '0, 1'b1);
                end
            end
            FUNC_FLUSH:
            begin
                // write back oldest to newest, returning each slot to the free ring
                while (age_cnt != 0)
                begin
                    s = age_ring[age_head];
                    age_head++;
                    age_cnt--;
                    victim            = slot_page[s];
                    map_valid[victim] = 1'b0;
                    push_result(KIND_WRITEBACK, s, victim, 1'b0);
                    pos            = free_head + free_cnt[3:0];
                    free_ring[pos] = s;
                    free_cnt++;
                end
                push_result(KIND_FLUSH_DONE, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Plan builders
    task automatic add_req(logic [FUNC_W-1:0] f, logic [PAGE_W-1:0] pg);
        step_t st;
        st.kind      = STEP_REQ;
        st.beat.func = f;
        st.beat.page = pg;
        st.wb_en     = 1'b0;
        pending_steps.push_back(st);
    endtask

    task automatic add_cfg(logic v);
        step_t st;
        st.kind  = STEP_CFG;
        st.beat  = '0;
        st.wb_en = v;
        pending_steps.push_back(st);
    endtask

    task automatic add_drain();
        step_t st;
        st.kind  = STEP_DRAIN;
        st.beat  = '0;
        st.wb_en = 1'b0;
        pending_steps.push_back(st);
    endtask

    // Mostly reads and writes on a small page set so the cache fills and evicts
    task automatic add_random_requests(int count);
        int                roll;
        logic [PAGE_W-1:0] pg;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            pg   = hot_pages[$urandom_range(0, HOT_COUNT - 1)];
            if (roll < 52)
                add_req(FUNC_WRITE, pg);
            else if (roll < 80)
                add_req(FUNC_READ, pg);
            else if (roll < 90)
                add_req($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, PAGE_W'($urandom));
            else if (roll < 94)
                add_req(FUNC_FLUSH, PAGE_W'($urandom));
            else if (roll < 98)
                add_req(FUNC_UNUSED, PAGE_W'($urandom));
            else
                add_drain();
        end
    endtask

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_beats
        logic v_nxt;
        req_t r_nxt;
        logic w_nxt;
        logic d_nxt;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
            cfg_write <= 1'b0;
            cfg_data  <= 1'b0;
        end
        else
        begin
            v_nxt = req_valid;
            r_nxt = req;
            w_nxt = 1'b0;
            d_nxt = cfg_data;
            if (req_valid && !req_stall)
            begin
                resolve_request(req);
                req_sent++;
                v_nxt    = 1'b0;
                send_gap = draw_wait(send_quiet);
            end
            // quiet time since the last expected result, for config writes
            if (!v_nxt && exp_total == got_total)
                settle++;
            else
                settle = 0;
            if (!v_nxt && pending_steps.size() != 0)
            begin
                if (pending_steps[0].kind == STEP_REQ)
                begin
                    if (send_gap == 0)
                    begin
                        v_nxt = 1'b1;
                        r_nxt = pending_steps[0].beat;
                        void'(pending_steps.pop_front());
                    end
                    else
                        send_gap--;
                end
                else if (pending_steps[0].kind == STEP_CFG)
                begin
                    if (settle >= SETTLE_CYCLES)
                    begin
                        w_nxt     = 1'b1;
                        d_nxt     = pending_steps[0].wb_en;
                        wb_enable = pending_steps[0].wb_en;
                        void'(pending_steps.pop_front());
                    end
                end
                else if (exp_total == got_total)
                    void'(pending_steps.pop_front());
            end
            req_valid <= v_nxt;
            req       <= r_nxt;
            cfg_write <= w_nxt;
            cfg_data  <= d_nxt;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        rsp_t want;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= REPORT_CAP)
                        $display("%0t: unexpected result kind %0d slot %0d victim %h last %0d",
                                 $time, rsp.kind, rsp.slot, rsp.victim_page, rsp.last);
                end
                else
                begin
                    want = due_results.pop_front();
                    got_total <= got_total + 1;
                    if (rsp.kind !== want.kind || rsp.slot !== want.slot ||
                        rsp.victim_page !== want.victim_page || rsp.last !== want.last)
                    begin
                        err_count++;
                        if (err_count <= REPORT_CAP)
                            $display({"%0t: mismatch, expected kind %0d slot %0d victim %h",
                                      " last %0d, got kind %0d slot %0d victim %h last %0d"},
                                     $time, want.kind, want.slot, want.victim_page, want.last,
                                     rsp.kind, rsp.slot, rsp.victim_page, rsp.last);
                    end
                end
                if (rsp.kind === KIND_WRITEBACK)
                    wb_seen++;
                if (rsp.kind === KIND_WRITE_REJECT)
                    rej_seen++;
                rcv_hold = draw_wait(rcv_quiet);
            end
            if (rcv_hold > 0)
            begin
                rsp_stall <= 1'b1;
                rcv_hold--;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    // Hard stop if the block hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Plan, reset and end of run
    initial
    begin
        // cache state after reset
        for (int p = 0; p < MAP_DEPTH; p++)
        begin
            map_valid[p] = 1'b0;
            map_slot[p]  = '0;
        end
        for (int s = 0; s < N_SLOTS; s++)
        begin
            slot_page[s] = '0;
            free_ring[s] = SLOTF_W'(s);
            age_ring[s]  = '0;
        end
        free_head = '0;
        free_cnt  = 5'(N_SLOTS);
        age_head  = '0;
        age_cnt   = '0;
        wb_enable = 1'b1;
        for (int h = 0; h < HOT_COUNT; h++)
            hot_pages[h] = PAGE_W'($urandom);

        // directed: every kind, extreme pages, empty flush, eviction, reject
        add_cfg(1'b1);
        add_req(FUNC_READ, 16'h0000);
        add_req(FUNC_WRITE, 16'h0000);
        add_req(FUNC_READ, 16'h0000);
        add_req(FUNC_WRITE, 16'h0000);
        add_req(FUNC_WRITE, 16'hFFFF);
        add_req(FUNC_READ, 16'hFFFF);
        add_req(FUNC_UNUSED, 16'h5A5A);
        add_req(FUNC_FLUSH, 16'hFFFF);
        add_req(FUNC_FLUSH, 16'h0000);
        for (int i = 0; i < N_SLOTS; i++)
            add_req(FUNC_WRITE, PAGE_W'(16'h0100 + i));
        add_req(FUNC_WRITE, 16'h8000);
        add_cfg(1'b0);
        add_req(FUNC_WRITE, 16'h4000);
        add_cfg(1'b1);

        // random phases over both settings, with a full pause mid phase
        add_random_requests(25);
        add_drain();
        add_random_requests(20);
        add_cfg(1'b0);
        add_random_requests(30);
        add_cfg(1'b1);
        add_random_requests(30);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_steps.size() != 0 || req_valid)
            @(negedge clk);
        while (exp_total != got_total)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (due_results.size() != 0)
        begin
            err_count++;
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
        end

        $display("Sent %0d requests, checked %0d result beats (%0d write-backs, %0d rejects),",
                 req_sent, got_total, wb_seen, rej_seen);
        $display("with write-back on and off over a mixed random workload.");
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pcfw_pkg.sv
design/pcfw_page_map.sv
design/pcfw_slot_owner.sv
design/pcfw_ctrl.sv
design/page_cache_fifo_writeback_core.sv
tb/sv/tb_page_cache_fifo_writeback_core.sv
